// ----- design/lts_pkg.sv -----
// Shared types, token kind codes and keyword table of the Lisp token scanner.
package lts_pkg;

    localparam int POS_BITS = 16;
    localparam int KW_CHARS = 7;
    localparam int KW_COUNT = 18;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    localparam logic [0:0] CMD_CHAR = 1'b0;
    localparam logic [0:0] CMD_END  = 1'b1;

    localparam logic [5:0] K_TRUE       = 6'd6;
    localparam logic [5:0] K_EOF        = 6'd18;
    localparam logic [5:0] K_LPAREN     = 6'd19;
    localparam logic [5:0] K_NIL        = 6'd20;
    localparam logic [5:0] K_RPAREN     = 6'd21;
    localparam logic [5:0] K_LBRACE     = 6'd22;
    localparam logic [5:0] K_RBRACE     = 6'd23;
    localparam logic [5:0] K_COMMA      = 6'd24;
    localparam logic [5:0] K_DOT        = 6'd25;
    localparam logic [5:0] K_MINUS      = 6'd26;
    localparam logic [5:0] K_PLUS       = 6'd27;
    localparam logic [5:0] K_STAR       = 6'd28;
    localparam logic [5:0] K_BANG_EQ    = 6'd29;
    localparam logic [5:0] K_BANG       = 6'd30;
    localparam logic [5:0] K_EQ_EQ      = 6'd31;
    localparam logic [5:0] K_EQ         = 6'd32;
    localparam logic [5:0] K_LESS_EQ    = 6'd33;
    localparam logic [5:0] K_LESS       = 6'd34;
    localparam logic [5:0] K_GREATER_EQ = 6'd35;
    localparam logic [5:0] K_GREATER    = 6'd36;
    localparam logic [5:0] K_SLASH      = 6'd37;
    localparam logic [5:0] K_IDENT      = 6'd38;
    localparam logic [5:0] K_NUMBER     = 6'd39;
    localparam logic [5:0] K_SYMBOL     = 6'd40;
    localparam logic [5:0] K_ERR_CHAR   = 6'd41;
    localparam logic [5:0] K_ERR_STRING = 6'd42;
    localparam logic [5:0] K_LAST_CODE  = K_ERR_STRING;

    typedef logic [0:KW_CHARS-1][7:0] word_prefix_t;

    typedef struct packed {
        logic [0:0] command;
        logic [7:0] char_code;
    } scan_in_t;

    typedef struct packed {
        logic [5:0]          token_kind;
        logic [POS_BITS-1:0] token_start;
        logic [POS_BITS-1:0] token_length;
        logic [POS_BITS-1:0] line_number;
        logic                last;
    } token_t;

    // Keywords, left aligned and zero padded; kind equals table index.
    localparam logic [KW_COUNT-1:0][KW_CHARS*8-1:0] KW_TEXT = {
        {"define", 8'h0}, {"nil?", 24'h0}, {"list?", 16'h0}, "symbol?",
        "number?", {"set", 32'h0}, {"car", 32'h0}, {"cdr", 32'h0},
        {"cond", 24'h0}, {"cons", 24'h0}, {"var", 32'h0}, {"true", 24'h0},
        {"this", 24'h0}, {"return", 8'h0}, {"print", 16'h0}, {"if", 40'h0},
        {"for", 32'h0}, {"false", 16'h0}
    };
    localparam logic [KW_COUNT-1:0][2:0] KW_LEN = {
        3'd6, 3'd4, 3'd5, 3'd7, 3'd7, 3'd3, 3'd3, 3'd3, 3'd4,
        3'd4, 3'd3, 3'd4, 3'd4, 3'd6, 3'd5, 3'd2, 3'd3, 3'd5
    };

    function automatic logic [5:0] kw_lookup(input word_prefix_t pfx,
                                             input logic [POS_BITS-1:0] len);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (len == POS_BITS'(KW_LEN[i]) && pfx == KW_TEXT[i]) begin
                kind = 6'(i);
            end
        end
        return kind;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "?";
    endfunction

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_diff(input logic [POS_BITS-1:0] a,
                                                     input logic [POS_BITS-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage

// ----- design/lisp_token_scanner.sv -----
// Top level of the Lisp token scanner: byte scanner plus token queue.
//
//  Channel | Direction | Payload          | Transfer
//  s_      | in        | scan_in_t        | s_valid && s_ready: one byte or end item
//  m_      | out       | token_t          | m_valid && m_ready: one token
//
// Each accepted item is scanned in the cycle it is accepted; its zero to three
// tokens are written together into a four-entry queue. One item per cycle is
// sustained while each item yields at most one token and tokens drain one per
// cycle; s_ready drops only while the queue has fewer than three free entries.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner
// to idle at offset 0, line 1. A stall on m_ holds the queue head unchanged.
module lisp_token_scanner (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lts_pkg::scan_in_t s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lts_pkg::token_t m_data
);
    import lts_pkg::*;

    typedef enum logic [13:0] {
        M_IDLE    = 14'b00000000000001,
        M_BANG    = 14'b00000000000010,
        M_EQ      = 14'b00000000000100,
        M_LESS    = 14'b00000000001000,
        M_GREATER = 14'b00000000010000,
        M_SEMI    = 14'b00000000100000,
        M_SLASH   = 14'b00000001000000,
        M_QUOTE   = 14'b00000010000000,
        M_WORD    = 14'b00000100000000,
        M_INT     = 14'b00001000000000,
        M_DOT     = 14'b00010000000000,
        M_FRAC    = 14'b00100000000000,
        M_STRING  = 14'b01000000000000,
        M_COMMENT = 14'b10000000000000
    } mode_t;

    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);

    // Scanner state
    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] origin_reg, origin_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    word_prefix_t        prefix_reg, prefix_next;
    logic [POS_BITS-1:0] wlen_reg, wlen_next;
    logic                paren_reg, paren_next;

    // Token queue
    token_t              queue_reg [QDEPTH];
    logic [QPTR-1:0]     rd_ptr_reg, wr_ptr_reg;
    logic [QPTR:0]       count_reg;

    token_t              slot [3];
    logic [1:0]          n_tok;
    logic                accept, pop, taken;
    logic [7:0]          c;
    logic [POS_BITS-1:0] p, dot_pos, q_start;
    logic [5:0]          op_kind;

    assign accept  = s_valid && s_ready;
    assign pop     = m_valid && m_ready;
    assign s_ready = count_reg <= (QPTR+1)'(QDEPTH - 3);
    assign m_valid = count_reg != '0;
    assign m_data  = queue_reg[rd_ptr_reg];
    assign c       = s_data.char_code;
    assign p       = pos_reg;
    assign dot_pos = (pos_reg != '0) ? pos_reg - 1'b1 : '0;
    assign q_start = sat_inc(origin_reg);

    always_comb begin
        case (mode_reg)
            M_BANG:  op_kind = K_BANG;
            M_EQ:    op_kind = K_EQ;
            M_LESS:  op_kind = K_LESS;
            default: op_kind = K_GREATER;
        endcase
    end

    always_comb begin
        mode_next   = mode_reg;
        origin_next = origin_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        prefix_next = prefix_reg;
        wlen_next   = wlen_reg;
        paren_next  = paren_reg;
        n_tok       = '0;
        taken       = 1'b1;
        for (int i = 0; i < 3; i++) begin
            slot[i] = '{K_EOF, '0, '0, line_reg, 1'b0};
        end

        if (accept && s_data.command == CMD_END) begin
            // Flush the pending token, then end of file; start over.
            case (mode_reg)
                M_BANG, M_EQ, M_LESS, M_GREATER: begin
                    slot[n_tok] = '{op_kind, origin_reg, POS_BITS'(1), line_reg, 1'b0};
                    n_tok++;
                end
                M_SEMI, M_SLASH: begin
                    slot[n_tok] = '{K_SLASH, origin_reg, POS_BITS'(1), line_reg, 1'b0};
                    n_tok++;
                end
                M_WORD: begin
                    slot[n_tok] = '{kw_lookup(prefix_reg, wlen_reg), origin_reg,
                                    sat_diff(p, origin_reg), line_reg, 1'b0};
                    n_tok++;
                end
                M_INT, M_FRAC: begin
                    slot[n_tok] = '{K_NUMBER, origin_reg, sat_diff(p, origin_reg),
                                    line_reg, 1'b0};
                    n_tok++;
                end
                M_DOT: begin
                    slot[n_tok] = '{K_NUMBER, origin_reg, sat_diff(dot_pos, origin_reg),
                                    line_reg, 1'b0};
                    n_tok++;
                    slot[n_tok] = '{K_DOT, dot_pos, POS_BITS'(1), line_reg, 1'b0};
                    n_tok++;
                end
                M_STRING: begin
                    slot[n_tok] = '{K_ERR_STRING, origin_reg, sat_diff(p, origin_reg),
                                    line_reg, 1'b0};
                    n_tok++;
                end
                default: ;
            endcase
            slot[n_tok] = '{K_EOF, p, '0, line_reg, 1'b0};
            n_tok++;
            mode_next   = M_IDLE;
            origin_next = '0;
            pos_next    = '0;
            line_next   = POS_BITS'(1);
            prefix_next = '0;
            wlen_next   = '0;
            paren_next  = 1'b0;
        end else if (accept) begin
            paren_next = 1'b0;
            case (mode_reg)
                M_BANG, M_EQ, M_LESS, M_GREATER: begin
                    if (c == "=") begin
                        slot[n_tok] = '{op_kind - 1'b1, origin_reg,
                                        sat_diff(sat_inc(p), origin_reg), line_reg, 1'b0};
                        n_tok++;
                        mode_next = M_IDLE;
                    end else begin
                        slot[n_tok] = '{op_kind, origin_reg, POS_BITS'(1), line_reg, 1'b0};
                        n_tok++;
                        taken = 1'b0;
                    end
                end
                M_SEMI, M_SLASH: begin
                    if ((mode_reg == M_SEMI && c == ";") || (mode_reg == M_SLASH && c == "/")) begin
                        mode_next = M_COMMENT;
                    end else begin
                        slot[n_tok] = '{K_SLASH, origin_reg, POS_BITS'(1), line_reg, 1'b0};
                        n_tok++;
                        taken = 1'b0;
                    end
                end
                M_QUOTE: begin
                    if (c == "t") begin
                        slot[n_tok] = '{K_TRUE, origin_reg,
                                        sat_diff(sat_inc(p), origin_reg), line_reg, 1'b0};
                        n_tok++;
                        mode_next = M_IDLE;
                    end else begin
                        taken = 1'b0;
                    end
                end
                M_WORD: begin
                    if (is_letter(c) || is_num(c)) begin
                        if (wlen_reg < POS_BITS'(KW_CHARS)) begin
                            prefix_next[wlen_reg[2:0]] = c;
                        end
                        wlen_next = sat_inc(wlen_reg);
                    end else begin
                        slot[n_tok] = '{kw_lookup(prefix_reg, wlen_reg), origin_reg,
                                        sat_diff(p, origin_reg), line_reg, 1'b0};
                        n_tok++;
                        taken = 1'b0;
                    end
                end
                M_INT: begin
                    if (c == ".") begin
                        mode_next = M_DOT;
                    end else if (!is_num(c)) begin
                        slot[n_tok] = '{K_NUMBER, origin_reg, sat_diff(p, origin_reg),
                                        line_reg, 1'b0};
                        n_tok++;
                        taken = 1'b0;
                    end
                end
                M_DOT: begin
                    if (is_num(c)) begin
                        mode_next = M_FRAC;
                    end else begin
                        slot[n_tok] = '{K_NUMBER, origin_reg, sat_diff(dot_pos, origin_reg),
                                        line_reg, 1'b0};
                        n_tok++;
                        slot[n_tok] = '{K_DOT, dot_pos, POS_BITS'(1), line_reg, 1'b0};
                        n_tok++;
                        taken = 1'b0;
                    end
                end
                M_FRAC: begin
                    if (!is_num(c)) begin
                        slot[n_tok] = '{K_NUMBER, origin_reg, sat_diff(p, origin_reg),
                                        line_reg, 1'b0};
                        n_tok++;
                        taken = 1'b0;
                    end
                end
                M_STRING: begin
                    if (c == "\"") begin
                        slot[n_tok] = '{K_SYMBOL, q_start, sat_diff(p, q_start),
                                        line_reg, 1'b0};
                        n_tok++;
                        mode_next = M_IDLE;
                    end else if (c == "\n") begin
                        line_next = sat_inc(line_reg);
                    end
                end
                M_COMMENT: begin
                    if (c == "\n") begin
                        taken = 1'b0;
                    end
                end
                default: taken = 1'b0;
            endcase

            // Byte not consumed by the open token: scan it from idle.
            if (!taken) begin
                mode_next = M_IDLE;
                case (c)
                    "(": begin
                        slot[n_tok] = '{K_LPAREN, p, POS_BITS'(1), line_reg, 1'b0};
                        n_tok++;
                        origin_next = p;
                        paren_next  = 1'b1;
                    end
                    ")": begin
                        if (paren_reg) begin
                            slot[n_tok] = '{K_NIL, origin_reg, POS_BITS'(1), line_reg, 1'b0};
                            n_tok++;
                        end
                        slot[n_tok] = '{K_RPAREN, p, POS_BITS'(1), line_reg, 1'b0};
                        n_tok++;
                    end
                    "{", "}", ",", ".", "-", "+", "*": begin
                        case (c)
                            "{":     slot[n_tok].token_kind = K_LBRACE;
                            "}":     slot[n_tok].token_kind = K_RBRACE;
                            ",":     slot[n_tok].token_kind = K_COMMA;
                            ".":     slot[n_tok].token_kind = K_DOT;
                            "-":     slot[n_tok].token_kind = K_MINUS;
                            "+":     slot[n_tok].token_kind = K_PLUS;
                            default: slot[n_tok].token_kind = K_STAR;
                        endcase
                        slot[n_tok].token_start  = p;
                        slot[n_tok].token_length = POS_BITS'(1);
                        n_tok++;
                    end
                    "!": begin origin_next = p; mode_next = M_BANG;    end
                    "=": begin origin_next = p; mode_next = M_EQ;      end
                    "<": begin origin_next = p; mode_next = M_LESS;    end
                    ">": begin origin_next = p; mode_next = M_GREATER; end
                    ";": begin origin_next = p; mode_next = M_SEMI;    end
                    "/": begin origin_next = p; mode_next = M_SLASH;   end
                    "\"": begin origin_next = p; mode_next = M_STRING; end
                    "'": begin origin_next = p; mode_next = M_QUOTE;   end
                    " ", 8'h0D, "\t": ;
                    "\n": line_next = sat_inc(line_reg);
                    default: begin
                        if (is_num(c)) begin
                            origin_next = p;
                            mode_next   = M_INT;
                        end else if (is_letter(c)) begin
                            origin_next    = p;
                            prefix_next    = '0;
                            prefix_next[0] = c;
                            wlen_next      = POS_BITS'(1);
                            mode_next      = M_WORD;
                        end else begin
                            slot[n_tok] = '{K_ERR_CHAR, p, POS_BITS'(1), line_reg, 1'b0};
                            n_tok++;
                        end
                    end
                endcase
            end
            pos_next = sat_inc(p);
        end

        // Mark the final token of this item.
        if (n_tok != '0) begin
            slot[n_tok - 1'b1].last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            origin_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= POS_BITS'(1);
            prefix_reg <= '0;
            wlen_reg   <= '0;
            paren_reg  <= 1'b0;
        end else begin
            mode_reg   <= mode_next;
            origin_reg <= origin_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            prefix_reg <= prefix_next;
            wlen_reg   <= wlen_next;
            paren_reg  <= paren_next;
        end
    end

    // Write all tokens of one item at once; drain one per transfer.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < n_tok) begin
                queue_reg[wr_ptr_reg + QPTR'(i)] <= slot[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR'(n_tok);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR+1)'(n_tok) - (QPTR+1)'(pop);
        end
    end

endmodule

// ----- design/lts_checker.sv -----
// Port-level checks of the Lisp token scanner and their bind.
module lts_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input lts_pkg::scan_in_t s_data,
    input logic            m_valid,
    input logic            m_ready,
    input lts_pkg::token_t m_data
);
    import lts_pkg::*;

    // Hold a stalled token.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled token changed or dropped");

    // Tokens of one item are queued together: no gap before the last one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last |=> m_valid)
        else $error("gap inside the tokens of one item");

    // An end item always yields a token on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_data.command == CMD_END |=> m_valid)
        else $error("end item produced no token");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.line_number != '0 && m_data.token_kind <= K_LAST_CODE)
        else $error("token with bad line or kind");

endmodule

bind lisp_token_scanner lts_checker u_lts_checker (.*);
